[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SCL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("switch code lock property violated");

// When the first condition holds, the second must hold in the next cycle.
`define SCL_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("switch code lock property violated");

`endif

[hdl/scl_pkg.sv]
// ----------------------------------------------------------------------------
// Switch code lock package
// Widths, codes, defaults and the result type shared by the lock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package scl_pkg;

    localparam int SWITCH_W = 8;
    localparam int PANEL_W = 2;
    localparam int STAGE_OUT_W = 4;

    localparam int CODE_LENGTH_DEFAULT = 4;
    localparam int CODE_LENGTH_MAX = 8;

    localparam logic [SWITCH_W-1:0] SWITCH_NONE = 8'h00;
    localparam logic [SWITCH_W-1:0] UNLOCK_CODE = 8'h01;

    localparam logic [PANEL_W-1:0] PANEL_OFF = 2'b00;
    localparam logic [PANEL_W-1:0] PANEL_UNLOCK = 2'b10;
    localparam logic [PANEL_W-1:0] PANEL_BOTH = 2'b11;

    typedef struct packed {
        logic [SWITCH_W-1:0]    flash_pattern;
        logic                   flash_now;
        logic [PANEL_W-1:0]     panel_level;
        logic                   panel_flash;
        logic [STAGE_OUT_W-1:0] stage_now;
    } result_t;

    // Code byte held after reset at a given position: one switch, moving down.
    function automatic logic [SWITCH_W-1:0] code_reset(input int unsigned idx);
        logic [2:0] sh;
        sh = idx[2:0];
        return 8'h80 >> sh;
    endfunction

endpackage

`default_nettype wire

[hdl/scl_if.sv]
// ----------------------------------------------------------------------------
// Switch code lock channels
// Valid/ready channels for switch polls and for lock results.
// ----------------------------------------------------------------------------
`default_nettype none

interface scl_poll_if;
    logic                          valid;
    logic                          ready;
    logic [scl_pkg::SWITCH_W-1:0]  switches;

    modport source (output valid, output switches, input ready);
    modport sink (input valid, input switches, output ready);
endinterface

interface scl_result_if;
    logic                            valid;
    logic                            ready;
    logic [scl_pkg::SWITCH_W-1:0]    flash_pattern;
    logic                            flash_now;
    logic [scl_pkg::PANEL_W-1:0]     panel_level;
    logic                            panel_flash;
    logic [scl_pkg::STAGE_OUT_W-1:0] stage_now;

    modport source (output valid, output flash_pattern, output flash_now,
                    output panel_level, output panel_flash, output stage_now,
                    input ready);
    modport sink (input valid, input flash_pattern, input flash_now,
                  input panel_level, input panel_flash, input stage_now,
                  output ready);
endinterface

`default_nettype wire

[hdl/scl_core.sv]
// ----------------------------------------------------------------------------
// Switch code lock core
// Holds the stage, code bytes, shown pattern and panel LEDs, and works out
// the result of one poll combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module scl_core #(
    parameter int CODE_LENGTH = scl_pkg::CODE_LENGTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [scl_pkg::SWITCH_W-1:0] switches,
    output scl_pkg::result_t                  result_next
);

    localparam int STAGE_OPEN = CODE_LENGTH;
    localparam int STAGE_FAILED_I = 2 * CODE_LENGTH + 1;
    localparam int STAGE_W = $clog2(2 * CODE_LENGTH + 2);
    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [STAGE_W-1:0] STAGE_ZERO = '0;
    localparam logic [STAGE_W-1:0] STAGE_ONE = STAGE_W'(1);
    localparam logic [STAGE_W-1:0] STAGE_ENTRY_END = STAGE_W'(STAGE_OPEN);
    localparam logic [STAGE_W-1:0] STAGE_FAILED = STAGE_W'(STAGE_FAILED_I);
    localparam logic [STAGE_W-1:0] STAGE_FIRST_REC = STAGE_W'(STAGE_OPEN + 1);
    localparam logic [IDX_W-1:0] SLOT_FIRST = '0;
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(CODE_LENGTH - 1);

    logic [STAGE_W-1:0]           stage_reg, stage_next;
    logic [scl_pkg::SWITCH_W-1:0] code_reg [CODE_LENGTH];
    logic [scl_pkg::SWITCH_W-1:0] code_next [CODE_LENGTH];
    logic [scl_pkg::SWITCH_W-1:0] shown_reg, shown_next;
    logic [scl_pkg::PANEL_W-1:0]  panel_reg, panel_next;

    logic [IDX_W-1:0]             entry_idx;
    logic [IDX_W-1:0]             slot;
    logic [scl_pkg::SWITCH_W-1:0] code_or;
    logic                         flash;
    logic [scl_pkg::SWITCH_W-1:0] pattern;
    logic                         fail_flash;

    assign entry_idx = stage_reg[IDX_W-1:0];
    assign slot = IDX_W'(stage_reg - STAGE_FIRST_REC);

    // On the last recorded byte the new byte stands in for the old one.
    always_comb
    begin
        code_or = switches;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (IDX_W'(i) != slot)
            begin
                code_or = code_or | code_reg[i];
            end
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        code_next = code_reg;
        shown_next = shown_reg;
        panel_next = panel_reg;
        flash = 1'b0;
        pattern = scl_pkg::SWITCH_NONE;
        fail_flash = 1'b0;

        if (stage_reg < STAGE_ENTRY_END)
        begin
            if (switches == scl_pkg::SWITCH_NONE)
            begin
                flash = 1'b1;
                pattern = shown_reg;
            end
            else if (switches == code_reg[entry_idx])
            begin
                shown_next = shown_reg | switches;
                flash = 1'b1;
                pattern = shown_reg | switches;
                stage_next = stage_reg + STAGE_ONE;
            end
            else
            begin
                stage_next = STAGE_FAILED;
                panel_next = scl_pkg::PANEL_OFF;
                fail_flash = 1'b1;
            end
        end
        else if (stage_reg == STAGE_ENTRY_END)
        begin
            if (switches == scl_pkg::UNLOCK_CODE)
            begin
                panel_next = scl_pkg::PANEL_UNLOCK;
                stage_next = stage_reg + STAGE_ONE;
            end
            else if (switches == scl_pkg::SWITCH_NONE)
            begin
                flash = 1'b1;
                pattern = shown_reg;
            end
        end
        else if (stage_reg < STAGE_FAILED)
        begin
            if (switches != scl_pkg::SWITCH_NONE)
            begin
                if (slot == SLOT_FIRST)
                begin
                    panel_next = scl_pkg::PANEL_BOTH;
                    shown_next = scl_pkg::SWITCH_NONE;
                end
                code_next[slot] = switches;
                if (slot == SLOT_LAST)
                begin
                    flash = 1'b1;
                    pattern = code_or;
                    shown_next = scl_pkg::SWITCH_NONE;
                    stage_next = STAGE_ZERO;
                end
                else
                begin
                    stage_next = stage_reg + STAGE_ONE;
                end
            end
        end
        else
        begin
            stage_next = STAGE_FAILED;
        end

        result_next.flash_pattern = pattern;
        result_next.flash_now = flash;
        result_next.panel_level = panel_next;
        result_next.panel_flash = fail_flash;
        result_next.stage_now = scl_pkg::STAGE_OUT_W'(stage_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STAGE_ZERO;
            shown_reg <= scl_pkg::SWITCH_NONE;
            panel_reg <= scl_pkg::PANEL_OFF;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                code_reg[i] <= scl_pkg::code_reset(i);
            end
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            shown_reg <= shown_next;
            panel_reg <= panel_next;
            code_reg <= code_next;
        end
    end

    `SCL_ASSERT(a_stage_in_range, stage_reg <= STAGE_FAILED)
    `SCL_ASSERT_NEXT(a_failed_sticks, stage_reg == STAGE_FAILED, stage_reg == STAGE_FAILED)
    `SCL_ASSERT_NEXT(a_fail_enters_failed, step && result_next.panel_flash,
                     stage_reg == STAGE_FAILED && panel_reg == scl_pkg::PANEL_OFF)

endmodule

`default_nettype wire

[hdl/switch_code_lock_top.sv]
// ----------------------------------------------------------------------------
// Switch code lock
// Combination lock polled from an 8-bit switch bank, with a poll register,
// a lock core and a result register.
//
//   Channel  Direction  Payload
//   poll     sink       switches
//   result   source     flash_pattern, flash_now, panel_level, panel_flash,
//                       stage_now
//
// One poll item is accepted every cycle when results are taken.
// A poll passes through the poll register, then the result register.
// The lock state is updated in the same cycle as the result register loads.
// A stalled result holds the poll register, which holds the poll channel.
// Reset returns to stage 0 with the default code bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module switch_code_lock_top #(
    parameter int CODE_LENGTH = scl_pkg::CODE_LENGTH_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    scl_poll_if.sink      poll,
    scl_result_if.source  result
);

    logic                         poll_valid_reg, poll_valid_next;
    logic [scl_pkg::SWITCH_W-1:0] switches_reg;
    logic                         res_valid_reg, res_valid_next;
    scl_pkg::result_t             res_reg;
    scl_pkg::result_t             core_result;
    logic                         load;
    logic                         poll_ready;
    logic                         poll_take;

    assign load = poll_valid_reg && (!res_valid_reg || result.ready);
    assign poll_ready = !poll_valid_reg || load;
    assign poll_take = poll.valid && poll_ready;

    assign poll_valid_next = poll_take ? 1'b1 : (load ? 1'b0 : poll_valid_reg);
    assign res_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);

    scl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (load),
        .switches    (switches_reg),
        .result_next (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            poll_valid_reg <= poll_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_take)
        begin
            switches_reg <= poll.switches;
        end
        if (load)
        begin
            res_reg <= core_result;
        end
    end

    assign poll.ready = poll_ready;
    assign result.valid = res_valid_reg;
    assign result.flash_pattern = res_reg.flash_pattern;
    assign result.flash_now = res_reg.flash_now;
    assign result.panel_level = res_reg.panel_level;
    assign result.panel_flash = res_reg.panel_flash;
    assign result.stage_now = res_reg.stage_now;

    `SCL_ASSERT(a_ready_when_empty, !res_valid_reg |-> poll_ready)
    `SCL_ASSERT(a_quiet_pattern,
                res_valid_reg |-> (res_reg.flash_now || res_reg.flash_pattern == '0))
    `SCL_ASSERT(a_fail_no_flash,
                res_valid_reg && res_reg.panel_flash |-> !res_reg.flash_now)

endmodule

`default_nettype wire
